FILE: rtl/psi_pkg.sv
// ----------------------------------------------------------------------------
// psi_pkg - shared definitions for the polygon store / point inclusion block
// Default sizes, the input item kind code, and the area accumulator limits.
// ----------------------------------------------------------------------------
package psi_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 24;

  // Fewest stored vertices that still bound a region
  localparam int MIN_POLY_VERTS = 3;

  // Area accumulator and reported area widths
  localparam int ACC_W  = 64;
  localparam int AREA_W = 56;

  localparam logic signed [ACC_W-1:0] ACC_LIM     = 64'sh4000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] ACC_LIM_NEG = -64'sh4000_0000_0000_0000;
  localparam logic [AREA_W-1:0]       AREA_MAX    = 56'hFF_FFFF_FFFF_FFFF;

  // Input item kind
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

endpackage

FILE: rtl/polygon_store_point_inclusion.sv
// ----------------------------------------------------------------------------
// polygon_store_point_inclusion - polygon vertex store with area and inclusion
// Load beats build a polygon (shoelace sum, bounding box, top z); query beats
// walk the stored edges and answer inside/outside by crossing parity.
// ----------------------------------------------------------------------------
// Sequence: a load beat passes S_LD_STORE, S_LD_TERM (no result); a closing
//   load beat goes on through S_LD_CMUL and S_LD_CACC and S_DONE gives its
//   summary. A query over n >= 3 stored vertices makes n + 1 reads of the
//   vertex memory, one a cycle, into a 3-stage difference / multiply / compare
//   pipe; below 3 vertices it skips the walk. Throughput: one beat at a time;
//   the single memory read port sets the query rate at about one edge per cycle.
// Reset: synchronous, active low; control state cleared at once, the vertex
//   memory is not cleared (entries are read only after they are written).
// ----------------------------------------------------------------------------
module polygon_store_point_inclusion #(
  parameter int MAX_VERTICES = psi_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = psi_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic signed [COORD_BITS-1:0]     in_coord_x,
  input  logic signed [COORD_BITS-1:0]     in_coord_y,
  input  logic signed [COORD_BITS-1:0]     in_coord_z,
  input  logic                             in_last_vertex,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_result_kind,
  output logic [psi_pkg::AREA_W-1:0]       out_area_twice,
  output logic signed [COORD_BITS-1:0]     out_box_min_x,
  output logic signed [COORD_BITS-1:0]     out_box_max_x,
  output logic signed [COORD_BITS-1:0]     out_box_min_y,
  output logic signed [COORD_BITS-1:0]     out_box_max_y,
  output logic signed [COORD_BITS-1:0]     out_top_z,
  output logic                             out_inside_res,
  output logic                             out_overflow
);

  localparam int CB     = COORD_BITS;
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int PROD_W = 2 * (CB + 1);
  localparam int ACC_W  = psi_pkg::ACC_W;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,      // waiting for a beat
    S_LD_STORE,  // open polygon, write vertex, box update, edge products
    S_LD_TERM,   // add edge term to the shoelace sum
    S_LD_CMUL,   // closing edge products (last vertex x first vertex)
    S_LD_CACC,   // add closing term, close the polygon
    S_Q_WALK,    // stream vertices through the crossing pipe
    S_DONE       // hand the result to the output register
  } state_t;

  state_t state_r;

  // Captured beat
  psi_pkg::kind_t          kind_r;
  logic signed [CB-1:0]    px_r, py_r, pz_r;
  logic                    last_r;

  // Polygon state
  logic                    open_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [CB-1:0]    minx_r, maxx_r, miny_r, maxy_r, topz_r;
  logic                    ovf_r;
  logic signed [CB-1:0]    head_x_r, head_y_r, last_x_r, last_y_r;
  logic                    term_r;

  // Vertex memory, x in the upper half, y in the lower
  logic [2*CB-1:0]         mem [MAX_VERTICES];
  logic [2*CB-1:0]         rd_data_r;

  // Query walk
  logic                    iss_busy_r;
  logic [CNT_W-1:0]        iss_cnt_r;
  logic                    rdv_r, rdfirst_r;
  logic signed [CB-1:0]    prev_x_r, prev_y_r;
  logic                    s1v_r, s1_band_r, s1_dpos_r;
  logic signed [CB:0]      s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic                    s2v_r, s2_band_r, s2_dpos_r;
  logic                    parity_r;

  // Shared multipliers
  logic signed [CB:0]       m0a, m0b, m1a, m1b;
  logic signed [PROD_W-1:0] prod0_r, prod1_r;

  // Output register
  logic                    out_valid_r;

  // --------------------------------------------------------------------------
  // Saturating add into the shoelace accumulator
  // --------------------------------------------------------------------------
  function automatic logic signed [ACC_W-1:0] acc_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W:0]   term
  );
    logic signed [ACC_W-1:0] s;
    s = acc + {{(ACC_W-PROD_W-1){term[PROD_W]}}, term};
    if (s > psi_pkg::ACC_LIM) begin
      s = psi_pkg::ACC_LIM;
    end else if (s < psi_pkg::ACC_LIM_NEG) begin
      s = psi_pkg::ACC_LIM_NEG;
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                    in_take;
  logic [CNT_W-1:0]        eff_cnt;
  logic                    store_ok;
  logic signed [CB-1:0]    base_minx, base_maxx, base_miny, base_maxy, base_topz;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [CNT_W-1:0]        cnt_m1, iss_m1;
  logic signed [PROD_W:0]  term_diff;
  logic signed [CB-1:0]    cur_x, cur_y;
  logic                    band;
  logic signed [CB:0]      d_yj_yi, d_px_xi, d_xj_xi, d_py_yi;
  logic                    hit;
  logic                    walk_done;
  logic [ACC_W-1:0]        acc_abs;
  logic                    mag_sat;
  logic [psi_pkg::AREA_W-1:0] mag;
  logic                    out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // A load beat arriving with no polygon open starts a fresh one
  assign eff_cnt   = open_r ? cnt_r : '0;
  assign store_ok  = (eff_cnt < CNT_W'(MAX_VERTICES));
  assign base_minx = open_r ? minx_r : px_r;
  assign base_maxx = open_r ? maxx_r : px_r;
  assign base_miny = open_r ? miny_r : py_r;
  assign base_maxy = open_r ? maxy_r : py_r;
  assign base_topz = open_r ? topz_r : pz_r;

  assign wr_en   = (state_r == S_LD_STORE) && store_ok;
  assign wr_addr = eff_cnt[IDX_W-1:0];

  // Walk order: vertex n-1 first, then 0 .. n-1, so each read pairs with the
  // one before it and the wrap-around edge comes first
  assign cnt_m1  = cnt_r - 1'b1;
  assign iss_m1  = iss_cnt_r - 1'b1;
  assign rd_en   = (state_r == S_Q_WALK) && iss_busy_r;
  assign rd_addr = (iss_cnt_r == '0) ? cnt_m1[IDX_W-1:0] : iss_m1[IDX_W-1:0];

  assign term_diff = {prod0_r[PROD_W-1], prod0_r} - {prod1_r[PROD_W-1], prod1_r};

  // Stage 1: edge differences, cur is vertex i, prev is vertex j
  assign cur_x   = rd_data_r[2*CB-1:CB];
  assign cur_y   = rd_data_r[CB-1:0];
  assign band    = (cur_y > py_r) != (prev_y_r > py_r);
  assign d_yj_yi = {prev_y_r[CB-1], prev_y_r} - {cur_y[CB-1], cur_y};
  assign d_px_xi = {px_r[CB-1], px_r} - {cur_x[CB-1], cur_x};
  assign d_xj_xi = {prev_x_r[CB-1], prev_x_r} - {cur_x[CB-1], cur_x};
  assign d_py_yi = {py_r[CB-1], py_r} - {cur_y[CB-1], cur_y};

  // Stage 3: compare direction follows the sign of the edge's y step
  assign hit = s2v_r && s2_band_r &&
               (s2_dpos_r ? (prod0_r < prod1_r) : (prod0_r > prod1_r));

  assign walk_done = !iss_busy_r && !rdv_r && !s1v_r && !s2v_r;

  // Summary magnitude
  assign acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign mag_sat = acc_abs > ACC_W'(psi_pkg::AREA_MAX);
  assign mag     = mag_sat ? psi_pkg::AREA_MAX : acc_abs[psi_pkg::AREA_W-1:0];

  // Multiplier operand select: edge terms while loading, crossing products
  // during the walk
  always_comb begin
    unique case (state_r)
      S_LD_STORE: begin
        m0a = {last_x_r[CB-1], last_x_r};
        m0b = {py_r[CB-1], py_r};
        m1a = {px_r[CB-1], px_r};
        m1b = {last_y_r[CB-1], last_y_r};
      end
      S_LD_CMUL: begin
        m0a = {last_x_r[CB-1], last_x_r};
        m0b = {head_y_r[CB-1], head_y_r};
        m1a = {head_x_r[CB-1], head_x_r};
        m1b = {last_y_r[CB-1], last_y_r};
      end
      default: begin
        m0a = s1_a_r;
        m0b = s1_d_r;
        m1a = s1_b_r;
        m1b = s1_c_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Vertex memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {px_r, py_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Payload pipeline registers (no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod0_r <= m0a * m0b;
    prod1_r <= m1a * m1b;
    if (rdv_r) begin
      prev_x_r  <= cur_x;
      prev_y_r  <= cur_y;
      s1_band_r <= band;
      s1_dpos_r <= !d_yj_yi[CB] && (d_yj_yi != '0);
      s1_a_r    <= d_px_xi;
      s1_b_r    <= d_xj_xi;
      s1_c_r    <= d_py_yi;
      s1_d_r    <= d_yj_yi;
    end
    s2_band_r <= s1_band_r;
    s2_dpos_r <= s1_dpos_r;
  end

  // --------------------------------------------------------------------------
  // Sequencer, polygon state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= '0;
      minx_r      <= '0;
      maxx_r      <= '0;
      miny_r      <= '0;
      maxy_r      <= '0;
      topz_r      <= '0;
      ovf_r       <= 1'b0;
      head_x_r    <= '0;
      head_y_r    <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      term_r      <= 1'b0;
      iss_busy_r  <= 1'b0;
      iss_cnt_r   <= '0;
      rdv_r       <= 1'b0;
      rdfirst_r   <= 1'b0;
      s1v_r       <= 1'b0;
      s2v_r       <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // walk pipe tokens; the first read only primes the previous vertex
      rdv_r     <= rd_en;
      rdfirst_r <= rd_en && (iss_cnt_r == '0);
      s1v_r     <= rdv_r && !rdfirst_r;
      s2v_r     <= s1v_r;
      if (hit) begin
        parity_r <= !parity_r;
      end

      // a taken beat empties the output unless S_DONE refills it this cycle
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            kind_r <= psi_pkg::kind_t'(in_kind);
            px_r   <= in_coord_x;
            py_r   <= in_coord_y;
            pz_r   <= in_coord_z;
            last_r <= in_last_vertex;
            if (psi_pkg::kind_t'(in_kind) == psi_pkg::KIND_QUERY) begin
              parity_r <= 1'b0;
              if (cnt_r >= CNT_W'(psi_pkg::MIN_POLY_VERTS)) begin
                iss_busy_r <= 1'b1;
                iss_cnt_r  <= '0;
                state_r    <= S_Q_WALK;
              end else begin
                state_r <= S_DONE;
              end
            end else begin
              state_r <= S_LD_STORE;
            end
          end
        end

        S_LD_STORE: begin
          open_r <= 1'b1;
          if (!open_r) begin
            acc_r <= '0;
          end
          if (store_ok) begin
            cnt_r  <= eff_cnt + 1'b1;
            minx_r <= (px_r < base_minx) ? px_r : base_minx;
            maxx_r <= (px_r > base_maxx) ? px_r : base_maxx;
            miny_r <= (py_r < base_miny) ? py_r : base_miny;
            maxy_r <= (py_r > base_maxy) ? py_r : base_maxy;
            topz_r <= (pz_r > base_topz) ? pz_r : base_topz;
            if (eff_cnt == '0) begin
              head_x_r <= px_r;
              head_y_r <= py_r;
            end
            last_x_r <= px_r;
            last_y_r <= py_r;
            ovf_r    <= open_r ? ovf_r : 1'b0;
          end else begin
            // store full: vertex dropped
            cnt_r <= eff_cnt;
            ovf_r <= 1'b1;
          end
          term_r  <= store_ok && (eff_cnt != '0);
          state_r <= S_LD_TERM;
        end

        S_LD_TERM: begin
          if (term_r) begin
            acc_r <= acc_add(acc_r, term_diff);
          end
          state_r <= last_r ? S_LD_CMUL : S_IDLE;
        end

        S_LD_CMUL: begin
          state_r <= S_LD_CACC;
        end

        S_LD_CACC: begin
          acc_r   <= acc_add(acc_r, term_diff);
          open_r  <= 1'b0;
          state_r <= S_DONE;
        end

        S_Q_WALK: begin
          if (rd_en) begin
            if (iss_cnt_r == cnt_r) begin
              iss_busy_r <= 1'b0;
            end else begin
              iss_cnt_r <= iss_cnt_r + 1'b1;
            end
          end
          if (walk_done) begin
            state_r <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (kind_r == psi_pkg::KIND_QUERY) begin
              out_result_kind <= 1'b1;
              out_area_twice  <= '0;
              out_box_min_x   <= '0;
              out_box_max_x   <= '0;
              out_box_min_y   <= '0;
              out_box_max_y   <= '0;
              out_top_z       <= '0;
              out_inside_res  <= parity_r;
              out_overflow    <= ovf_r;
            end else begin
              out_result_kind <= 1'b0;
              out_area_twice  <= mag;
              out_box_min_x   <= minx_r;
              out_box_max_x   <= maxx_r;
              out_box_min_y   <= miny_r;
              out_box_max_y   <= maxy_r;
              out_top_z       <= topz_r;
              out_inside_res  <= 1'b0;
              out_overflow    <= ovf_r || mag_sat;
              ovf_r           <= ovf_r || mag_sat;
            end
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule
